FILE: rtl/ssnf_pkg.sv
package ssnf_pkg;

	localparam int ValueW = 14;
	localparam int PortW  = 8;
	localparam int SegW   = 8;
	localparam int ModeW  = 2;

	localparam logic [ModeW-1:0] MODE_FOUR = 2'd0;
	localparam logic [ModeW-1:0] MODE_TWO  = 2'd1;
	localparam logic [ModeW-1:0] MODE_RAW  = 2'd2;
	localparam logic [ModeW-1:0] MODE_NONE = 2'd3;

	localparam logic [ValueW-1:0] ValueMax = 14'd9999;

	// reciprocal of ten scaled by 2^19, exact for all 14-bit values
	localparam logic [15:0] RecipTen   = 16'd52429;
	localparam int          RecipShift = 19;

	typedef logic [SegW-1:0] seg_t;

	// active-low segment codes for digits 0..9
	function automatic seg_t seg_code(input logic [3:0] digit);
		seg_t code;
		unique case (digit)
			4'd0:    code = 8'hC0;
			4'd1:    code = 8'hF9;
			4'd2:    code = 8'hA4;
			4'd3:    code = 8'hB0;
			4'd4:    code = 8'h99;
			4'd5:    code = 8'h92;
			4'd6:    code = 8'h82;
			4'd7:    code = 8'hF8;
			4'd8:    code = 8'h80;
			4'd9:    code = 8'h90;
			default: code = 8'hFF;
		endcase
		return code;
	endfunction

endpackage

FILE: rtl/seven_segment_number_frames.sv
// Seven-segment number frames: each input word asks for a number to be shown on a
// multiplexed seven-segment display and yields one output word per shown digit, ones
// digit first, each carrying an active-low segment byte and a digit-select byte, with
// tlast on the final word of the request. Mode 0 shows up to four digits (selects 1, 2,
// 4, 8) with leading zeros blanked unless show_zeros is set, values above 9999 shown as
// 9999; mode 1 shows the two lowest digits at select port and port<<1; mode 2 passes
// value[7:0] and port through as one word; mode 3 is taken and dropped. An item yields
// 1 to 4 output words from the digit sequencer, which peels off one decimal digit per
// cycle while the output register can take a word, with a single reciprocal multiply; the next item is taken in
// the cycle its predecessor's last word moves to the output register.
module seven_segment_number_frames (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // value[13:0], port[21:14], zero fill[23:22]
	input  logic [2:0]  s_tuser,   // mode[1:0], show_zeros[2]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // segments[7:0], digit_select[15:8]
	output logic        m_tlast
);
	import ssnf_pkg::*;

	// input word fields
	logic [ValueW-1:0] in_value;
	logic [PortW-1:0]  in_port;
	logic [ModeW-1:0]  in_mode;
	logic              in_zeros;
	logic [ValueW-1:0] in_sat;
	logic [1:0]        in_last_idx;
	logic              accept;

	// sequencer state
	logic              busy_q;
	logic [ValueW-1:0] rem_q;      // value still to be split into digits
	logic [ModeW-1:0]  mode_q;
	logic [PortW-1:0]  port_q;
	logic [SegW-1:0]   raw_q;
	logic [1:0]        idx_q;      // frame number within the request
	logic [1:0]        last_idx_q; // number of the final frame

	// digit extraction
	logic [29:0]       prod;
	logic [10:0]       quot;
	logic [ValueW-1:0] quot_x10;
	logic [ValueW-1:0] diff;
	logic [3:0]        digit;

	// frame being formed
	logic [SegW-1:0]   frame_seg;
	logic [PortW-1:0]  frame_sel;
	logic              frame_last;
	logic              advance;

	assign in_value = s_tdata[ValueW-1:0];
	assign in_port  = s_tdata[ValueW+PortW-1:ValueW];
	assign in_mode  = s_tuser[ModeW-1:0];
	assign in_zeros = s_tuser[ModeW];

	assign in_sat = (in_value > ValueMax) ? ValueMax : in_value;

	// how many frames follow the ones digit
	always_comb begin
		unique case (in_mode)
			MODE_FOUR: begin
				if (in_zeros || in_sat > 14'd999)
					in_last_idx = 2'd3;
				else if (in_sat > 14'd99)
					in_last_idx = 2'd2;
				else if (in_sat > 14'd9)
					in_last_idx = 2'd1;
				else
					in_last_idx = 2'd0;
			end
			MODE_TWO:  in_last_idx = 2'd1;
			MODE_RAW:  in_last_idx = 2'd0;
			MODE_NONE: in_last_idx = 2'd0;
			default:   in_last_idx = 2'd0;
		endcase
	end

	// x / 10 by reciprocal, then x mod 10 by shift-add
	assign prod     = {16'd0, rem_q} * {14'd0, RecipTen};
	assign quot     = prod[29:RecipShift];
	assign quot_x10 = {quot[10:0], 3'b000} + {2'b00, quot[10:0], 1'b0};
	assign diff     = rem_q - quot_x10;
	assign digit    = diff[3:0];

	always_comb begin
		unique case (mode_q)
			MODE_FOUR: begin
				frame_seg = seg_code(digit);
				frame_sel = 8'h01 << idx_q;
			end
			MODE_TWO: begin
				frame_seg = seg_code(digit);
				frame_sel = (idx_q == 2'd0) ? port_q : {port_q[PortW-2:0], 1'b0};
			end
			MODE_RAW: begin
				frame_seg = raw_q;
				frame_sel = port_q;
			end
			default: begin
				frame_seg = raw_q;
				frame_sel = port_q;
			end
		endcase
	end

	assign frame_last = (idx_q == last_idx_q);

	// a frame moves on when the output register is free or being emptied
	assign advance  = busy_q && (!m_tvalid || m_tready);
	assign s_tready = !busy_q || (advance && frame_last);
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= (in_mode != MODE_NONE);
		end else if (advance && frame_last) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rem_q      <= (in_mode == MODE_FOUR) ? in_sat : in_value;
			mode_q     <= in_mode;
			port_q     <= in_port;
			raw_q      <= in_value[SegW-1:0];
			idx_q      <= 2'd0;
			last_idx_q <= in_last_idx;
		end else if (advance) begin
			rem_q <= {3'b000, quot};
			idx_q <= idx_q + 2'd1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_tdata <= {frame_sel, frame_seg};
			m_tlast <= frame_last;
		end
	end

endmodule

FILE: bench/tb_seven_segment_number_frames.sv
module tb_seven_segment_number_frames;

	import ssnf_pkg::*;

	localparam int ClkHalf     = 10;
	localparam int ResetCycles = 12;
	localparam int IdlePct     = 34;
	localparam int RandomItems = 288;
	localparam int DrainCycles = 12;   // margin for stray words after the last expected frame
	localparam int QuietLimit  = 2000; // far beyond any idle run at 34 percent

	// active-low digit patterns, segment a in bit 0, dp off
	localparam logic [7:0] DIGIT_SEGS [10] = '{
		8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
	};

	// select bytes of the four-digit mode, ones digit first
	localparam logic [7:0] SEL_ONES  = 8'h01;
	localparam logic [7:0] SEL_TENS  = 8'h02;
	localparam logic [7:0] SEL_HUNDS = 8'h04;
	localparam logic [7:0] SEL_THOUS = 8'h08;

	typedef struct packed {
		seg_t       segments;
		logic [7:0] digit_select;
		logic       last;
	} frame_t;

	// expected display frames, one queue entry per output word
	class frame_scoreboard;
		frame_t pending_frames[$];
		int     errors;

		function new();
			errors = 0;
		endfunction

		function int pending();
			return pending_frames.size();
		endfunction

		task report_mismatch(input string what);
			errors++;
			$display("%0t mismatch: %s", $time, what);
		endtask

		// work out the frames one accepted request must produce
		function void note_request(input logic [1:0] mode, input logic [ValueW-1:0] value,
				input logic zeros, input logic [7:0] port);
			logic [7:0] segs [4];
			logic [7:0] sels [4];
			int         n;
			int         v;
			frame_t     f;

			n = 0;
			case (mode)
				MODE_FOUR: begin
					v = (value > ValueMax) ? int'(ValueMax) : int'(value);
					segs[n] = DIGIT_SEGS[v % 10];          sels[n] = SEL_ONES;  n++;
					if (zeros || v > 9) begin
						segs[n] = DIGIT_SEGS[(v / 10) % 10];   sels[n] = SEL_TENS;  n++;
					end
					if (zeros || v > 99) begin
						segs[n] = DIGIT_SEGS[(v / 100) % 10];  sels[n] = SEL_HUNDS; n++;
					end
					if (zeros || v > 999) begin
						segs[n] = DIGIT_SEGS[(v / 1000) % 10]; sels[n] = SEL_THOUS; n++;
					end
				end
				MODE_TWO: begin
					v = int'(value);
					segs[n] = DIGIT_SEGS[v % 10];        sels[n] = port;               n++;
					segs[n] = DIGIT_SEGS[(v / 10) % 10]; sels[n] = {port[6:0], 1'b0}; n++;
				end
				MODE_RAW: begin
					segs[n] = value[7:0]; sels[n] = port; n++;
				end
				default: begin
				end
			endcase
			for (int i = 0; i < n; i++) begin
				f.segments     = segs[i];
				f.digit_select = sels[i];
				f.last         = (i == n - 1);
				pending_frames.push_back(f);
			end
		endfunction

		task check_frame(input logic [7:0] segments, input logic [7:0] digit_select,
				input logic last);
			frame_t want;

			if (pending_frames.size() == 0) begin
				report_mismatch($sformatf("word %h/%h/%b with nothing expected",
					segments, digit_select, last));
			end else begin
				want = pending_frames.pop_front();
				if (segments !== want.segments) begin
					report_mismatch($sformatf("segments %h, expected %h",
						segments, want.segments));
				end
				if (digit_select !== want.digit_select) begin
					report_mismatch($sformatf("digit_select %h, expected %h",
						digit_select, want.digit_select));
				end
				if (last !== want.last) begin
					report_mismatch($sformatf("tlast %b, expected %b", last, want.last));
				end
			end
		endtask
	endclass

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata  = '0;
	logic [2:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tlast;

	// while set, neither side idles
	logic steady = 1'b0;
	int   quiet_cycles;

	frame_scoreboard frames_sb;

	seven_segment_number_frames dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // value[13:0], port[21:14], zero fill[23:22]
		.s_tuser  (s_tuser),   // mode[1:0], show_zeros[2]
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // segments[7:0], digit_select[15:8]
		.m_tlast  (m_tlast)
	);

	initial begin
		forever begin
			#ClkHalf clk = ~clk;
		end
	end

	// offer one request word, with random idle cycles ahead of it, and
	// hand it to the scoreboard once the block takes it
	task automatic send_request(input logic [1:0] mode, input logic [ValueW-1:0] value,
			input logic zeros, input logic [7:0] port);
		while (!steady && $urandom_range(99) < IdlePct) begin
			s_tvalid <= 1'b0;
			s_tdata  <= {2'b00, 22'($urandom)};   // junk payload while idle
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, port, value};
		s_tuser  <= {zeros, mode};
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		frames_sb.note_request(mode, value, zeros, port);
	endtask

	// number with a random count of decimal digits so every blanking case shows up
	function automatic logic [ValueW-1:0] pick_number();
		int r;

		r = $urandom_range(99);
		if (r < 6) begin
			return ValueW'($urandom);   // full field, saturation included
		end
		case ($urandom_range(3))
			0:       return ValueW'($urandom_range(9));
			1:       return ValueW'($urandom_range(99, 10));
			2:       return ValueW'($urandom_range(999, 100));
			default: return ValueW'($urandom_range(9999, 1000));
		endcase
	endfunction

	// main sequence: reset, directed words, random words, drain
	initial begin
		int          taken;
		int          r;
		logic [1:0]  mode;

		frames_sb = new();
		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// four-digit mode: blanking edges, leading zeros, saturation, digit four
		send_request(MODE_FOUR, 14'd0,     1'b0, 8'h00);
		send_request(MODE_FOUR, 14'd0,     1'b1, 8'hFF);
		send_request(MODE_FOUR, 14'd9,     1'b0, 8'h00);
		send_request(MODE_FOUR, 14'd10,    1'b0, 8'h00);
		send_request(MODE_FOUR, 14'd99,    1'b0, 8'h00);
		send_request(MODE_FOUR, 14'd100,   1'b0, 8'h00);
		send_request(MODE_FOUR, 14'd999,   1'b0, 8'h00);
		send_request(MODE_FOUR, 14'd1000,  1'b0, 8'h00);
		send_request(MODE_FOUR, 14'd9999,  1'b0, 8'h00);
		send_request(MODE_FOUR, 14'd10000, 1'b0, 8'h00);
		send_request(MODE_FOUR, 14'h3FFF,  1'b1, 8'h00);
		send_request(MODE_FOUR, 14'd5,     1'b1, 8'h00);
		send_request(MODE_FOUR, 14'd4444,  1'b0, 8'h00);
		send_request(MODE_FOUR, 14'd8642,  1'b1, 8'h00);
		// two-digit mode: select shift drops bit 7, higher digits dropped
		send_request(MODE_TWO,  14'd0,     1'b0, 8'h80);
		send_request(MODE_TWO,  14'd99,    1'b1, 8'hFF);
		send_request(MODE_TWO,  14'h3FFF,  1'b0, 8'h01);
		send_request(MODE_TWO,  14'd57,    1'b0, 8'h55);
		// raw mode: upper value bits ignored
		send_request(MODE_RAW,  14'h3FA5,  1'b0, 8'h5A);
		send_request(MODE_RAW,  14'd0,     1'b1, 8'h00);
		send_request(MODE_RAW,  14'h00FF,  1'b0, 8'hFF);
		// unused mode is swallowed without a word out
		send_request(MODE_NONE, 14'd1234,  1'b1, 8'h33);
		send_request(MODE_FOUR, 14'd42,    1'b0, 8'h00);

		// random part: mostly well-formed requests, a few of the unused mode
		taken = 0;
		while (taken < RandomItems) begin
			steady <= (taken >= 120 && taken < 190);
			r = $urandom_range(99);
			if (r < 45) begin
				mode = MODE_FOUR;
			end else if (r < 70) begin
				mode = MODE_TWO;
			end else if (r < 90) begin
				mode = MODE_RAW;
			end else begin
				mode = MODE_NONE;
			end
			send_request(mode, pick_number(), 1'($urandom), 8'($urandom));
			taken++;
		end
		s_tvalid <= 1'b0;
		steady   <= 1'b0;

		// wait for the last frames, then DrainCycles more for stray words
		while (frames_sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (DrainCycles) @(posedge clk);
		if (frames_sb.errors == 0) begin
			$display("tb_seven_segment_number_frames: done, clean");
		end else begin
			$display("tb_seven_segment_number_frames: done, errors");
		end
		$finish;
	end

	// output side: sample the word at the edge, then pick the next ready
	initial begin
		while (!arst_n) begin
			@(posedge clk);
		end
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				frames_sb.check_frame(m_tdata[7:0], m_tdata[15:8], m_tlast);
			end
			m_tready <= steady || ($urandom_range(99) >= IdlePct);
		end
	end

	// watchdog: too long without a word moving on either side
	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < QuietLimit) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("tb_seven_segment_number_frames: done, errors");
		$finish;
	end

endmodule
